@@ design/sact_pkg.sv @@
// Package for the set-associative cache tag controller.
// Holds geometry constants, field widths, register indexes and shared types.
// No dependencies.
package sact_pkg;

   localparam int WAYS       = 4;
   localparam int SET_COUNT  = 1024;
   localparam int LINE_BYTES = 32;
   localparam int ADDR_BITS  = 32;

   localparam int OFF_BITS  = $clog2(LINE_BYTES);
   localparam int IDX_BITS  = $clog2(SET_COUNT);
   localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - IDX_BITS;
   localparam int WAY_BITS  = $clog2(WAYS);
   localparam int ROW_BITS  = WAYS * (2 + TAG_BITS + WAY_BITS);

   localparam int HC_BITS   = 8;
   localparam int MC_BITS   = 10;
   localparam int COST_BITS = 12;
   localparam int CNT_BITS  = 32;

   localparam int                      CSR_IDX_BITS      = 2;
   localparam logic [CSR_IDX_BITS-1:0] REG_HIT_CYCLES    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MEMORY_CYCLES = 2'd1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // one way's entry: valid, dirty, tag, lru rank
   typedef struct packed {
      logic                valid;
      logic                dirty;
      logic [TAG_BITS-1:0] tag;
      logic [WAY_BITS-1:0] rank;
   } way_type;

   typedef way_type [WAYS-1:0] row_type;

   // front-to-back command
   typedef struct packed {
      logic                is_write;
      logic [IDX_BITS-1:0] set_idx;
      logic [TAG_BITS-1:0] tag;
   } cmd_type;

   typedef struct packed {
      logic                is_hit;
      logic [1:0]          way_used;
      logic                write_back;
      logic                evicted_valid;
      logic [16:0]         victim_tag;
      logic [COST_BITS-1:0] access_cost;
      logic [CNT_BITS-1:0] total_cycles;
      logic [CNT_BITS-1:0] hit_count;
      logic [CNT_BITS-1:0] access_count;
   } rsp_type;

   function automatic row_type reset_row();
      row_type r;
      for (int w = 0; w < WAYS; w++) begin
         r[w].valid = 1'b0;
         r[w].dirty = 1'b0;
         r[w].tag   = '0;
         r[w].rank  = WAY_BITS'(w);
      end
      return r;
   endfunction

endpackage

@@ design/sact_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sact_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/sact_front.sv @@
// Front end: accept accesses, split the address, push commands into a
// two-entry queue. Depends on sact_pkg.
module sact_front import sact_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic            in_write,
   input  logic [31:0]     in_addr,
   output logic            cmd_valid,
   input  logic            cmd_ready,
   output cmd_type         cmd
);
   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    new_cmd;
   logic       push, pop;
   logic [0:0] slot;

   always_comb begin
      new_cmd.is_write = in_write;
      new_cmd.set_idx  = in_addr[OFF_BITS +: IDX_BITS];
      new_cmd.tag      = in_addr[OFF_BITS + IDX_BITS +: TAG_BITS];
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[0];
   assign slot      = 1'(cnt_ff - {1'b0, pop});

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         q_in[slot] = new_cmd;
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end
endmodule

@@ design/sact_back.sv @@
// Back end: read the set row, compare ways, update LRU/dirty, write back
// the row, keep totals and hold the result. Depends on sact_pkg, sact_ram.
module sact_back import sact_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  cmd_type            cmd,
   input  logic [HC_BITS-1:0] hit_cycles,
   input  logic [MC_BITS-1:0] memory_cycles,
   output logic               out_valid,
   input  logic               out_ready,
   output rsp_type            out_rsp,
   output logic               clearing
);
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] clr_ff, clr_in;
   cmd_type             cur_ff, cur_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [CNT_BITS-1:0] tot_ff, tot_in, hits_ff, hits_in, acc_ff, acc_in;

   logic                wr_en;
   logic [IDX_BITS-1:0] wr_addr;
   logic [ROW_BITS-1:0] wr_data, rd_data;
   row_type             row, new_row;

   logic                hit;
   logic [WAY_BITS-1:0] way, old_rank;
   logic [COST_BITS-1:0] cost;
   logic [CNT_BITS:0]   tsum;

   sact_ram #(.WIDTH(ROW_BITS), .DEPTH(SET_COUNT)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(cmd.set_idx),
      .rd_data(rd_data)
   );

   assign row       = row_type'(rd_data);
   assign cmd_ready = (state_ff == ST_IDLE) && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;
   assign clearing  = (state_ff == ST_CLEAR);

   always_comb begin
      hit = 1'b0;
      way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row[w].valid && row[w].tag == cur_ff.tag) begin
            hit = 1'b1;
            way = WAY_BITS'(w);
         end
      end
      if (!hit) begin
         for (int w = 0; w < WAYS; w++) begin
            if (row[w].rank == '0) begin
               way = WAY_BITS'(w);
            end
         end
      end
      old_rank = row[way].rank;
      new_row  = row;
      for (int w = 0; w < WAYS; w++) begin
         if (row[w].rank > old_rank) begin
            new_row[w].rank = row[w].rank - 1'b1;
         end
      end
      new_row[way].rank = WAY_BITS'(WAYS - 1);
      if (hit) begin
         new_row[way].dirty = row[way].dirty | cur_ff.is_write;
      end else begin
         new_row[way].valid = 1'b1;
         new_row[way].dirty = cur_ff.is_write;
         new_row[way].tag   = cur_ff.tag;
      end
      cost = COST_BITS'(hit_cycles);
      if (!hit) begin
         cost = cost + COST_BITS'(memory_cycles);
         if (row[way].dirty) begin
            cost = cost + COST_BITS'(memory_cycles);
         end
      end
      tsum = {1'b0, tot_ff} + (CNT_BITS + 1)'(cost);
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      out_valid_in = out_valid_ff;
      rsp_in       = rsp_ff;
      tot_in       = tot_ff;
      hits_in      = hits_ff;
      acc_in       = acc_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = ROW_BITS'(reset_row());
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IDX_BITS'(SET_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cur_in   = cmd;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff.set_idx;
            wr_data = ROW_BITS'(new_row);
            tot_in  = tsum[CNT_BITS] ? '1 : tsum[CNT_BITS-1:0];
            hits_in = (hit && hits_ff != '1) ? hits_ff + 1'b1 : hits_ff;
            acc_in  = (acc_ff != '1) ? acc_ff + 1'b1 : acc_ff;
            rsp_in.is_hit        = hit;
            rsp_in.way_used      = 2'(way);
            rsp_in.write_back    = !hit && row[way].dirty;
            rsp_in.evicted_valid = !hit && row[way].valid;
            rsp_in.victim_tag    = (!hit && row[way].valid) ? 17'(row[way].tag) : '0;
            rsp_in.access_cost   = cost;
            rsp_in.total_cycles  = tot_in;
            rsp_in.hit_count     = hits_in;
            rsp_in.access_count  = acc_in;
            out_valid_in         = 1'b1;
            state_in             = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         tot_ff       <= '0;
         hits_ff      <= '0;
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
         tot_ff       <= tot_in;
         hits_ff      <= hits_in;
         acc_ff       <= acc_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end
endmodule

@@ design/set_assoc_cache_tag_controller.sv @@
// Top level of the set-associative cache tag controller (LRU, write-back,
// write-allocate). Depends on sact_pkg, sact_front, sact_back, sact_ram.
//
// Channel | Dir | Handshake           | Payload
// req     | in  | req_tvalid/tready   | tuser: opcode; tdata: address
// rsp     | out | rsp_tvalid/tready   | tdata: result fields (see port)
// csr     | in  | csr_valid/csr_ready | csr_index, csr_data
//
// Each access passes through the back-end states idle, where the set row is
// read from the tag RAM, and look, where the row is compared, updated and
// written back; a new access is taken only in idle, after look is done.
// After reset a clearing pass initialises all 1024 rows of the row RAM;
// lookups are held off (the queue still takes two words), configuration
// writes are taken.
// A two-entry queue parts the front from the back; a held result stalls the
// back end, and the queue keeps taking accesses until it fills.
module set_assoc_cache_tag_controller import sact_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] address
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] is_hit, [2:1] way_used, [3] write_back, [4] evicted_valid,
   // [21:5] victim_tag, [33:22] access_cost, [65:34] total_cycles,
   // [97:66] hit_count, [129:98] access_count, [135:130] zero
   output logic [135:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0] csr_data
);
   logic [HC_BITS-1:0] hit_cycles_ff;
   logic [MC_BITS-1:0] memory_cycles_ff;
   logic               cmd_valid, cmd_ready, clearing;
   cmd_type            cmd;
   rsp_type            rsp;

   assign csr_ready = 1'b1;

   // register file: out-of-range indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cycles_ff    <= HC_BITS'(1);
         memory_cycles_ff <= MC_BITS'(50);
      end else if (csr_valid) begin
         if (csr_index == CSR_IDX_BITS'(REG_HIT_CYCLES)) begin
            hit_cycles_ff <= csr_data[HC_BITS-1:0];
         end
         if (csr_index == CSR_IDX_BITS'(REG_MEMORY_CYCLES)) begin
            memory_cycles_ff <= csr_data[MC_BITS-1:0];
         end
      end
   end

   sact_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_write (req_tuser),
      .in_addr  (req_tdata),
      .cmd_valid(cmd_valid),
      .cmd_ready(cmd_ready),
      .cmd      (cmd)
   );

   sact_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .hit_cycles   (hit_cycles_ff),
      .memory_cycles(memory_cycles_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_rsp      (rsp),
      .clearing     (clearing)
   );

   assign rsp_tdata = {6'd0, rsp.access_count, rsp.hit_count, rsp.total_cycles,
                       rsp.access_cost, rsp.victim_tag, rsp.evicted_valid,
                       rsp.write_back, rsp.way_used, rsp.is_hit};

   // a hit never reports an eviction or write-back
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.is_hit |-> !rsp.write_back && !rsp.evicted_valid)
      else $error("hit reported eviction");

   // a write-back implies a valid victim
   a_wb_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.write_back |-> rsp.evicted_valid)
      else $error("write-back without valid victim");

   // no results during the clearing pass
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_tvalid)
      else $error("result during clearing");
endmodule
